// ===== design/lps_pkg.sv =====
// Shared types and constants for the LED pattern sequencer.
// No dependencies; compiled first.
`default_nettype none

package lps_pkg;

    localparam int OP_W      = 3;
    localparam int MODE_W    = 3;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 16;
    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_MODE    = 3'd1;
    localparam logic [OP_W-1:0] OP_PATTERN = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT   = 3'd3;
    localparam logic [OP_W-1:0] OP_BLINK   = 3'd4;
    localparam logic [OP_W-1:0] OP_PULSE   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FAST   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_KEEP   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL = 1'b1;

    localparam logic [TICK_W-1:0] SLOT_TICKS_RESET = 16'd100;

    // eight slots per blink: count is shifted left by three, saturating
    localparam int BLINK_SHIFT = 3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] pattern_word;
        logic [SLOT_W-1:0] slot_count;
        logic [TICK_W-1:0] pulse_ticks;
    } lps_cmd_t;

    typedef struct packed {
        logic led_lit;
        logic pulse_on;
    } lps_status_t;

endpackage

`default_nettype wire

// ===== design/lps_if.sv =====
// Request and result channel interfaces for the LED pattern sequencer.
// Depends on lps_pkg.
`default_nettype none

interface lps_cmd_if
    import lps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] pattern_word;
    logic [SLOT_W-1:0] slot_count;
    logic [TICK_W-1:0] pulse_ticks;

    modport source (output valid, op, mode, pattern_word, slot_count, pulse_ticks,
                    input ready);
    modport sink (input valid, op, mode, pattern_word, slot_count, pulse_ticks,
                  output ready);
endinterface

interface lps_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic pulse_busy;

    modport source (output valid, pin_level, pulse_busy, input ready);
    modport sink (input valid, pin_level, pulse_busy, output ready);
endinterface

`default_nettype wire

// ===== design/lps_engine.sv =====
// Sequencer state and its next-state logic: slot timer, pattern walker, pulse.
// Depends on lps_pkg.
`default_nettype none

module lps_engine
    import lps_pkg::*;
#(
    parameter int PATTERN_BITS = 32,
    parameter int TIMER_BITS   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire lps_cmd_t          cmd,
    input  wire logic [TICK_W-1:0] slot_ticks,
    output lps_status_t            status_next
);

    localparam logic [PATTERN_BITS-1:0] PAT_ONES = '1;
    localparam logic [PATTERN_BITS-1:0] PAT_MSB  = {1'b1, {(PATTERN_BITS-1){1'b0}}};

    logic [PATTERN_BITS-1:0] pattern_reg, pattern_next;
    logic [PATTERN_BITS-1:0] sel_reg, sel_next;
    logic [SLOT_W-1:0]       slots_reg, slots_next;
    logic                    pulse_reg, pulse_next;
    logic                    led_reg, led_next;
    logic                    armed_reg, armed_next;
    logic [TIMER_BITS-1:0]   ticks_reg, ticks_next;

    logic [PATTERN_BITS-1:0] pat_blink, pat_slow, pat_fast;
    logic [PATTERN_BITS-1:0] pat_load, pat_mode, sel_eff;
    logic [TIMER_BITS-1:0]   slot_t, pulse_t, ticks_dec;
    logic [SLOT_W-1:0]       blink_slots;
    logic                    pat_still;

    genvar g;
    generate
        for (g = 0; g < PATTERN_BITS; g++) begin : g_pat
            assign pat_blink[g] = ((g % 8) >= 4);
            assign pat_fast[g]  = ((g % 2) == 1);
            assign pat_slow[g]  = (g >= PATTERN_BITS - PATTERN_BITS / 2);
        end
        if (PATTERN_BITS > WORD_W) begin : g_pw
            assign pat_load = {{(PATTERN_BITS-WORD_W){1'b0}}, cmd.pattern_word};
        end
        else begin : g_pn
            assign pat_load = cmd.pattern_word[PATTERN_BITS-1:0];
        end
        if (TIMER_BITS > TICK_W) begin : g_tw
            assign slot_t  = {{(TIMER_BITS-TICK_W){1'b0}}, slot_ticks};
            assign pulse_t = {{(TIMER_BITS-TICK_W){1'b0}}, cmd.pulse_ticks};
        end
        else begin : g_tn
            assign slot_t  = slot_ticks[TIMER_BITS-1:0];
            assign pulse_t = cmd.pulse_ticks[TIMER_BITS-1:0];
        end
    endgenerate

    assign sel_eff   = (sel_reg == '0) ? PAT_MSB : sel_reg;
    assign ticks_dec = (ticks_reg == '0) ? '0 : ticks_reg - 1'b1;
    assign pat_still = (pattern_reg == '0) || (pattern_reg == PAT_ONES);

    assign blink_slots = (cmd.slot_count[SLOT_W-1 -: BLINK_SHIFT] != '0) ? '1
                       : {cmd.slot_count[SLOT_W-BLINK_SHIFT-1:0], {BLINK_SHIFT{1'b0}}};

    always_comb
    begin
        case (cmd.mode)
            MODE_BLINK: pat_mode = pat_blink;
            MODE_SLOW:  pat_mode = pat_slow;
            MODE_FAST:  pat_mode = pat_fast;
            MODE_FLASH: pat_mode = PAT_MSB;
            default:    pat_mode = pattern_reg;
        endcase
    end

    always_comb
    begin
        pattern_next = pattern_reg;
        sel_next     = sel_reg;
        slots_next   = slots_reg;
        pulse_next   = pulse_reg;
        led_next     = led_reg;
        armed_next   = armed_reg;
        ticks_next   = ticks_reg;
        unique case (cmd.op)
            OP_TICK:
            begin
                if (armed_reg)
                begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        armed_next = 1'b0;
                        if (pulse_reg)
                        begin
                            led_next   = 1'b0;
                            pulse_next = 1'b0;
                            sel_next   = '0;
                            armed_next = 1'b1;
                            ticks_next = slot_t;
                        end
                        else if (!pat_still)
                        begin
                            led_next = |(pattern_reg & sel_eff);
                            sel_next = sel_eff >> 1;
                            if (slots_reg != '0)
                            begin
                                slots_next = slots_reg - 1'b1;
                                if (slots_reg == SLOT_W'(1))
                                    pattern_next = '0;
                            end
                            armed_next = 1'b1;
                            ticks_next = slot_t;
                        end
                    end
                end
            end
            OP_MODE:
            begin
                case (cmd.mode)
                    MODE_TOGGLE:
                    begin
                        if (pattern_reg == '0)
                        begin
                            pattern_next = PAT_ONES;
                            slots_next   = '0;
                            led_next     = 1'b1;
                        end
                        else if (pattern_reg == PAT_ONES)
                        begin
                            pattern_next = '0;
                            slots_next   = '0;
                            if (!pulse_reg)
                                led_next = 1'b0;
                        end
                    end
                    MODE_OFF:
                    begin
                        pattern_next = '0;
                        slots_next   = '0;
                        if (!pulse_reg)
                            led_next = 1'b0;
                    end
                    MODE_ON:
                    begin
                        pattern_next = PAT_ONES;
                        slots_next   = '0;
                        if (!pulse_reg)
                            led_next = 1'b1;
                    end
                    default:
                    begin
                        if (pat_mode != pattern_reg)
                        begin
                            pattern_next = pat_mode;
                            sel_next     = '0;
                            slots_next   = '0;
                        end
                        armed_next = 1'b1;
                        ticks_next = '0;
                    end
                endcase
            end
            OP_PATTERN:
            begin
                pattern_next = pat_load;
                sel_next     = '0;
                armed_next   = 1'b1;
                ticks_next   = '0;
            end
            OP_COUNT:
                slots_next = cmd.slot_count;
            OP_BLINK:
            begin
                pattern_next = pat_blink;
                sel_next     = '0;
                slots_next   = blink_slots;
                armed_next   = 1'b1;
                ticks_next   = '0;
            end
            OP_PULSE:
            begin
                pulse_next = 1'b1;
                led_next   = pulse_reg ? led_reg : 1'b1;
                armed_next = 1'b1;
                ticks_next = pulse_t;
            end
            default:
            begin
            end
        endcase
    end

    assign status_next.led_lit  = led_next;
    assign status_next.pulse_on = pulse_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            sel_reg     <= '0;
            slots_reg   <= '0;
            pulse_reg   <= 1'b0;
            led_reg     <= 1'b0;
            armed_reg   <= 1'b0;
            ticks_reg   <= '0;
        end
        else if (en)
        begin
            pattern_reg <= pattern_next;
            sel_reg     <= sel_next;
            slots_reg   <= slots_next;
            pulse_reg   <= pulse_next;
            led_reg     <= led_next;
            armed_reg   <= armed_next;
            ticks_reg   <= ticks_next;
        end
    end

    // a pulse always holds the LED lit
    a_pulse_lit: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_reg |-> led_reg)
        else $error("pulse running with LED dark");

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_reg))
        else $error("slot selector not one-hot");

    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (ticks_reg == '0))
        else $error("disarmed timer holds a count");

endmodule

`default_nettype wire

// ===== design/led_pattern_sequencer_core.sv =====
// LED pin sequencer: one result per request, with a request register ahead of
// the sequencer state and a result register behind it, so one request a clock
// cycle is taken while the sink is ready; a request waits in the request
// register, then its result is registered. The rate is set by the next-state
// update of the sequencer state. A result waiting on a stalled sink holds one
// further request in the request register. Configuration (slot ticks at index
// 0, idle level at index 1) should be written while no request is in flight.
// Depends on lps_pkg, lps_cmd_if, lps_res_if and lps_engine.
`default_nettype none

module led_pattern_sequencer_core
    import lps_pkg::*;
#(
    parameter int PATTERN_BITS = 32,
    parameter int TIMER_BITS   = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    lps_cmd_if.sink                   cmd,
    lps_res_if.source                 res
);

    logic              slot_ticks_reg;
    logic [TICK_W-1:0] slot_ticks_q_reg;
    logic              idle_level_reg;

    logic     stage_valid_reg, stage_valid_next;
    lps_cmd_t stage_cmd_reg;
    logic     res_valid_reg, res_valid_next;
    logic     res_pin_reg, res_busy_reg;

    lps_cmd_t    cmd_in;
    lps_status_t status_next;
    logic        accept, advance;

    assign cmd_in.op           = cmd.op;
    assign cmd_in.mode         = cmd.mode;
    assign cmd_in.pattern_word = cmd.pattern_word;
    assign cmd_in.slot_count   = cmd.slot_count;
    assign cmd_in.pulse_ticks  = cmd.pulse_ticks;

    assign advance   = stage_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !stage_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    assign stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    assign res_valid_next   = advance ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ticks_reg   <= 1'b0;
            slot_ticks_q_reg <= SLOT_TICKS_RESET;
            idle_level_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOT_TICKS:
                begin
                    slot_ticks_reg   <= 1'b1;
                    slot_ticks_q_reg <= cfg_data;
                end
                REG_IDLE_LEVEL: idle_level_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_cmd_reg <= cmd_in;
        if (advance)
        begin
            res_pin_reg  <= status_next.led_lit ^ idle_level_reg;
            res_busy_reg <= status_next.pulse_on;
        end
    end

    lps_engine #(
        .PATTERN_BITS (PATTERN_BITS),
        .TIMER_BITS   (TIMER_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .cmd         (stage_cmd_reg),
        .slot_ticks  (slot_ticks_q_reg),
        .status_next (status_next)
    );

    assign res.valid      = res_valid_reg;
    assign res.pin_level  = res_pin_reg;
    assign res.pulse_busy = res_busy_reg;

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stage_valid_reg)
        else $error("accepted request lost from request register");

    a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("processed request produced no result");

    // a stalled result keeps the request register from moving on
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready && stage_valid_reg) |=>
            (stage_valid_reg && $stable(stage_cmd_reg)))
        else $error("request register overwritten during stall");

    a_cfg_written: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_SLOT_TICKS) |=> slot_ticks_reg)
        else $error("slot tick write not recorded");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for led_pattern_sequencer_core: directed table, then random requests.
// Expected pin levels come from a local model of the sequencer, or from the table for typed rows.
// Depends on lps_pkg, lps_cmd_if, lps_res_if and the core.
`default_nettype none

module tb;
    import lps_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [WORD_W-1:0] PAT_BLINK = 32'hF0F0_F0F0;
    localparam logic [WORD_W-1:0] PAT_SLOW  = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] PAT_FAST  = 32'hAAAA_AAAA;
    localparam logic [WORD_W-1:0] PAT_MSB   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] PAT_ONES  = 32'hFFFF_FFFF;
    localparam logic [SLOT_W-1:0] SLOTS_MAX = 16'hFFFF;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic pin;
        logic busy;
    } pin_status_t;

    typedef struct packed {
        lps_cmd_t req;
        logic     typed;
        logic     pin;
        logic     busy;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lps_cmd_if cmd();
    lps_res_if res();

    led_pattern_sequencer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .res       (res)
    );

    // sequencer model state
    logic [WORD_W-1:0] seq_pattern;
    logic [WORD_W-1:0] seq_select;
    logic [SLOT_W-1:0] seq_slots;
    logic              seq_pulsing;
    logic              seq_lit;
    logic              seq_armed;
    logic [TICK_W-1:0] seq_countdown;
    logic [TICK_W-1:0] cfg_slot_ticks;
    logic              cfg_idle;

    pin_status_t status_due [$];
    pin_status_t want;
    int          errors = 0;
    int          snd_idle_pct;
    int          rcv_idle_pct;

    row_t directed_rows [28] = '{
        {OP_TICK,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b0, 1'b0},
        {OP_MODE,    MODE_TOGGLE, 32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b1, 1'b0},
        {OP_MODE,    MODE_TOGGLE, 32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b0, 1'b0},
        {OP_MODE,    MODE_ON,     32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b1, 1'b0},
        {OP_MODE,    MODE_OFF,    32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b0, 1'b0},
        {OP_PATTERN, MODE_KEEP,   32'hFFFF_FFFF, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_TICK,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_PATTERN, MODE_KEEP,   32'h8000_0001, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_TICK,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_COUNT,   MODE_KEEP,   32'h0000_0000, 16'h0001, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_MODE,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_TICK,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_MODE,    MODE_FLASH,  32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_MODE,    MODE_BLINK,  32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_MODE,    MODE_SLOW,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_MODE,    MODE_FAST,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_MODE,    MODE_TOGGLE, 32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_BLINK,   MODE_KEEP,   32'h0000_0000, 16'hFFFF, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_BLINK,   MODE_KEEP,   32'h0000_0000, 16'h0001, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_TICK,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0},
        {OP_PULSE,   MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b1, 1'b1},
        {OP_MODE,    MODE_OFF,    32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b1, 1'b1},
        {OP_PULSE,   MODE_KEEP,   32'h0000_0000, 16'h0000, 16'hFFFF, TYPED,     1'b1, 1'b1},
        {OP_PULSE,   MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0001, PREDICTED, 1'b0, 1'b0},
        {OP_TICK,    MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, TYPED,     1'b0, 1'b0},
        {OP_SPARE_A, MODE_ON,     32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, TYPED,     1'b0, 1'b0},
        {OP_SPARE_B, MODE_ON,     32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, TYPED,     1'b0, 1'b0},
        {OP_PATTERN, MODE_KEEP,   32'h0000_0000, 16'h0000, 16'h0000, PREDICTED, 1'b0, 1'b0}
    };

    logic [TICK_W-1:0] phase_ticks [6] = '{16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd5, 16'd4};
    logic              phase_idle  [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb: FAIL");
        $finish;
    end

    task automatic arm_timer(input logic [TICK_W-1:0] ticks);
        seq_armed     = 1'b1;
        seq_countdown = ticks;
    endtask

    task automatic fire_slot();
        seq_armed = 1'b0;
        if (seq_pulsing)
        begin
            seq_lit     = 1'b0;
            seq_pulsing = 1'b0;
            seq_select  = '0;
            arm_timer(cfg_slot_ticks);
        end
        else if (seq_pattern != '0 && seq_pattern != PAT_ONES)
        begin
            if (seq_select == '0)
                seq_select = PAT_MSB;
            seq_lit    = |(seq_pattern & seq_select);
            seq_select = seq_select >> 1;
            if (seq_slots != '0)
            begin
                seq_slots = seq_slots - 1'b1;
                if (seq_slots == '0)
                    seq_pattern = '0;
            end
            arm_timer(cfg_slot_ticks);
        end
    endtask

    task automatic apply_mode(input logic [MODE_W-1:0] mode);
        logic [WORD_W-1:0] next_pat;
        next_pat = seq_pattern;
        case (mode)
            MODE_TOGGLE:
            begin
                if (seq_pattern == '0)
                begin
                    seq_pattern = PAT_ONES;
                    seq_slots   = '0;
                    seq_lit     = 1'b1;
                end
                else if (seq_pattern == PAT_ONES)
                begin
                    seq_pattern = '0;
                    seq_slots   = '0;
                    if (!seq_pulsing)
                        seq_lit = 1'b0;
                end
                return;
            end
            MODE_OFF:
            begin
                seq_pattern = '0;
                seq_slots   = '0;
                if (!seq_pulsing)
                    seq_lit = 1'b0;
                return;
            end
            MODE_ON:
            begin
                seq_pattern = PAT_ONES;
                seq_slots   = '0;
                if (!seq_pulsing)
                    seq_lit = 1'b1;
                return;
            end
            MODE_BLINK: next_pat = PAT_BLINK;
            MODE_SLOW:  next_pat = PAT_SLOW;
            MODE_FAST:  next_pat = PAT_FAST;
            MODE_FLASH: next_pat = PAT_MSB;
            default:    next_pat = seq_pattern;
        endcase
        if (next_pat != seq_pattern)
        begin
            seq_pattern = next_pat;
            seq_select  = '0;
            seq_slots   = '0;
        end
        arm_timer('0);
    endtask

    task automatic advance_sequencer(input lps_cmd_t r, output pin_status_t st);
        logic [SLOT_W+BLINK_SHIFT-1:0] blink_slots;
        case (r.op)
            OP_TICK:
            begin
                if (seq_armed)
                begin
                    if (seq_countdown != '0)
                        seq_countdown = seq_countdown - 1'b1;
                    if (seq_countdown == '0)
                        fire_slot();
                end
            end
            OP_MODE: apply_mode(r.mode);
            OP_PATTERN:
            begin
                seq_pattern = r.pattern_word;
                seq_select  = '0;
                arm_timer('0);
            end
            OP_COUNT: seq_slots = r.slot_count;
            OP_BLINK:
            begin
                blink_slots = {{BLINK_SHIFT{1'b0}}, r.slot_count} << BLINK_SHIFT;
                seq_pattern = PAT_BLINK;
                seq_select  = '0;
                seq_slots   = (blink_slots > SLOTS_MAX) ? SLOTS_MAX : blink_slots[SLOT_W-1:0];
                arm_timer('0);
            end
            OP_PULSE:
            begin
                if (!seq_pulsing)
                begin
                    seq_lit     = 1'b1;
                    seq_pulsing = 1'b1;
                end
                arm_timer(r.pulse_ticks);
            end
            default: ;
        endcase
        st.pin  = seq_lit ^ cfg_idle;
        st.busy = seq_pulsing;
    endtask

    function automatic lps_cmd_t random_request();
        lps_cmd_t r;
        int pick;
        r.op           = OP_TICK;
        r.mode         = MODE_W'($urandom_range(7));
        r.pattern_word = $urandom;
        r.slot_count   = SLOT_W'($urandom);
        r.pulse_ticks  = TICK_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
            r.op = OP_TICK;
        else if (pick < 65)
            r.op = OP_MODE;
        else if (pick < 73)
            r.op = OP_PATTERN;
        else if (pick < 80)
            r.op = OP_COUNT;
        else if (pick < 85)
            r.op = OP_BLINK;
        else if (pick < 95)
            r.op = OP_PULSE;
        else
            r.op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;

        pick = $urandom_range(9);
        case (pick)
            0: r.pattern_word = '0;
            1: r.pattern_word = PAT_ONES;
            2: r.pattern_word = PAT_MSB >> $urandom_range(31);
            3: r.pattern_word = ~(PAT_MSB >> $urandom_range(31));
            default: ;
        endcase

        pick = $urandom_range(9);
        if (r.op == OP_BLINK)
        begin
            if (pick < 7)
                r.slot_count = SLOT_W'($urandom_range(3));
            else if (pick < 9)
                r.slot_count = SLOT_W'($urandom_range(8193, 8191));
        end
        else if (pick < 7)
            r.slot_count = SLOT_W'($urandom_range(12));
        else if (pick == 7)
            r.slot_count = SLOTS_MAX;

        pick = $urandom_range(9);
        if (pick < 7)
            r.pulse_ticks = TICK_W'($urandom_range(6));
        else if (pick == 7)
            r.pulse_ticks = '1;
        return r;
    endfunction

    task automatic put_request(input lps_cmd_t r, input logic typed, input pin_status_t typed_st);
        pin_status_t st;
        while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.op           <= r.op;
        cmd.mode         <= r.mode;
        cmd.pattern_word <= r.pattern_word;
        cmd.slot_count   <= r.slot_count;
        cmd.pulse_ticks  <= r.pulse_ticks;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        advance_sequencer(r, st);
        status_due.push_back(typed ? typed_st : st);
    endtask

    // hold off requests until every pending result is back
    task automatic drain_requests();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [TICK_W-1:0] ticks, input logic idle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SLOT_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= REG_IDLE_LEVEL;
        cfg_data  <= {{(CFG_W-1){1'b0}}, idle};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_slot_ticks = ticks;
        cfg_idle       = idle;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result pin %0b busy %0b", $time,
                         res.pin_level, res.pulse_busy);
            end
            else
            begin
                want = status_due.pop_front();
                if (res.pin_level !== want.pin)
                begin
                    errors++;
                    $display("%0t: pin_level expected %0b actual %0b", $time,
                             want.pin, res.pin_level);
                end
                if (res.pulse_busy !== want.busy)
                begin
                    errors++;
                    $display("%0t: pulse_busy expected %0b actual %0b", $time,
                             want.busy, res.pulse_busy);
                end
            end
        end
        res.ready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
    end

    initial
    begin
        int       fed;
        lps_cmd_t r;

        snd_idle_pct = 26;
        rcv_idle_pct = 53;

        seq_pattern    = '0;
        seq_select     = '0;
        seq_slots      = '0;
        seq_pulsing    = 1'b0;
        seq_lit        = 1'b0;
        seq_armed      = 1'b0;
        seq_countdown  = '0;
        cfg_slot_ticks = SLOT_TICKS_RESET;
        cfg_idle       = 1'b0;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        cmd.valid        <= 1'b0;
        cmd.op           <= OP_TICK;
        cmd.mode         <= MODE_KEEP;
        cmd.pattern_word <= '0;
        cmd.slot_count   <= '0;
        cmd.pulse_ticks  <= '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            put_request(directed_rows[i].req, directed_rows[i].typed,
                        {directed_rows[i].pin, directed_rows[i].busy});

        for (int p = 0; p < 6; p++)
        begin
            drain_requests();
            write_config(phase_ticks[p], phase_idle[p]);
            case (p / 2)
                0:
                begin
                    snd_idle_pct = 26;
                    rcv_idle_pct = 53;
                end
                1:
                begin
                    snd_idle_pct = 53;
                    rcv_idle_pct = 26;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            fed = 0;
            while (fed < 255)
            begin
                r = random_request();
                put_request(r, PREDICTED, '0);
                if (r.op <= OP_PULSE)
                begin
                    fed++;
                    if (p == 1 && fed == 128)
                        drain_requests();
                end
            end
        end

        cmd.valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== led_pattern_sequencer_core.f =====
design/lps_pkg.sv
design/lps_if.sv
design/lps_engine.sv
design/led_pattern_sequencer_core.sv
dv/tb.sv
